FILE: rtl/core/bgf_pkg.sv
// Shared types, constants and command codes of the banded gradient fill generator.
package bgf_pkg;

  // Default coordinate width
  localparam int CoordBitsDefault = 16;

  // Color channels: red, green, blue
  localparam int NumCh = 3;
  localparam logic [1:0] LastCh = 2'(NumCh - 1);

  // Configuration register indexes
  localparam logic [2:0] CFG_FROM_COLOR  = 3'd0;
  localparam logic [2:0] CFG_TO_COLOR    = 3'd1;
  localparam logic [2:0] CFG_AREA_LEFT   = 3'd2;
  localparam logic [2:0] CFG_AREA_TOP    = 3'd3;
  localparam logic [2:0] CFG_AREA_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_AREA_HEIGHT = 3'd5;
  localparam logic [2:0] CFG_HORIZONTAL  = 3'd6;

  // Divider operations used during gradient setup
  localparam logic [2:0] OP_Q    = 3'd0;  // span / first band count
  localparam logic [2:0] OP_STEP = 3'd1;  // span / (quotient + 1)
  localparam logic [2:0] OP_SIZE = 3'd2;  // span / band count
  localparam logic [2:0] OP_D    = 3'd3;  // channel diff / band count
  localparam logic [2:0] OP_K    = 3'd4;  // (diff - count) / delta
  localparam logic [2:0] OP_IV   = 3'd5;  // band count / k

  typedef struct packed {
    logic restart;
  } in_item_t;

  typedef struct packed {
    logic [15:0] band_x;
    logic [15:0] band_y;
    logic [15:0] band_w;
    logic [15:0] band_h;
    logic [23:0] band_color;
    logic        last_band;
    logic        no_band;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       prep;       // latch diffs, directions, start color, first count
    logic       step_one;   // force band count to one
    logic       div_start;  // launch a division
    logic       div_store;  // capture the finished division
    logic [2:0] op;
    logic [1:0] ch;
    logic       finish;     // arm the gradient at band zero
    logic       emit;       // produce one result and advance
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic div_rem_nz;
    logic div_quo_zero;
    logic step0_zero;
    logic step_gt1;
    logic diff_gt_step;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/bgf_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface bgf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/bgf_div.sv
// Restoring divider, one quotient bit per cycle.
module bgf_div #(
  parameter int Width = bgf_pkg::CoordBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] dividend_i,
  input  logic [Width:0]   divisor_i,
  output logic [Width-1:0] quo_o,
  output logic [Width:0]   rem_o,
  output logic             done_o
);
  localparam int CntW = $clog2(Width + 1);

  logic [Width-1:0] quo_q, quo_d;
  logic [Width:0]   rem_q, rem_d;
  logic [Width:0]   dvs_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [Width+1:0] shifted, trial;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[Width-1]};
    trial   = shifted - {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (cnt_q != '0) begin
      if (!trial[Width+1]) begin
        rem_d = trial[Width:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = shifted[Width:0];
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(Width);
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;
endmodule

FILE: rtl/core/bgf_datapath.sv
// Datapath: configuration registers, gradient state, divider and output register.
module bgf_datapath #(
  parameter int CoordBits = bgf_pkg::CoordBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [23:0]   cfg_data_i,
  input  bgf_pkg::cmd_t cmd_i,
  output bgf_pkg::sts_t sts_o,
  bgf_stream_if.source  out_if
);
  import bgf_pkg::*;

  localparam int CW = CoordBits;
  localparam int VW = CoordBits + 1;

  // Configuration registers
  logic [23:0]   from_q, to_q;
  logic [CW-1:0] left_q, top_q, width_q, height_q;
  logic          horiz_q;

  // Gradient state
  logic          active_q;
  logic [7:0]    index_q;
  logic [7:0]    total_q;
  logic [CW-1:0] pos_q;
  logic [CW-1:0] size_q;
  logic [CW-1:0] span_q;
  logic [CW-1:0] q_q;
  logic [7:0]    step_q;
  logic [7:0]    k_q;
  logic [7:0]    cur_q   [NumCh];
  logic [7:0]    diff_q  [NumCh];
  logic [7:0]    delta_q [NumCh];
  logic [7:0]    iv_q    [NumCh];
  logic [7:0]    cnt_q   [NumCh];
  logic          rise_q  [NumCh];

  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  // Setup values taken from the live registers
  logic [7:0]    a_ch [NumCh];
  logic [7:0]    b_ch [NumCh];
  logic [7:0]    t_ch [NumCh];
  logic [7:0]    dif  [NumCh];
  logic          rise [NumCh];
  logic [7:0]    maxdiff;
  logic [CW-1:0] span;
  logic [7:0]    step0;

  always_comb begin
    maxdiff = '0;
    for (int i = 0; i < NumCh; i++) begin
      a_ch[i] = from_q[8*(NumCh-1-i) +: 8];
      b_ch[i] = to_q[8*(NumCh-1-i) +: 8];
      t_ch[i] = b_ch[i];
      rise[i] = (a_ch[i] <= b_ch[i]);
      dif[i]  = rise[i] ? b_ch[i] - a_ch[i] : a_ch[i] - b_ch[i];
      if (dif[i] > maxdiff) maxdiff = dif[i];
    end
    span  = horiz_q ? width_q : height_q;
    step0 = (CW'(maxdiff) > span) ? span[7:0] : maxdiff;
  end

  // Divider operand selection
  logic [CW-1:0] dvd, quo;
  logic [VW-1:0] dvs, rem;
  logic          div_done;

  always_comb begin
    unique case (cmd_i.op)
      OP_Q, OP_SIZE: begin
        dvd = span_q;
        dvs = VW'(step_q);
      end
      OP_STEP: begin
        dvd = span_q;
        dvs = {1'b0, q_q} + VW'(1);
      end
      OP_D: begin
        dvd = CW'(diff_q[cmd_i.ch]);
        dvs = VW'(step_q);
      end
      OP_K: begin
        dvd = CW'(diff_q[cmd_i.ch] - step_q);
        dvs = VW'(delta_q[cmd_i.ch]);
      end
      OP_IV: begin
        dvd = CW'(step_q);
        dvs = VW'(k_q);
      end
      default: begin
        dvd = '0;
        dvs = VW'(1);
      end
    endcase
  end

  bgf_div #(.Width(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .quo_o      (quo),
    .rem_o      (rem),
    .done_o     (div_done)
  );

  // Band result and the next colors
  logic          last;
  logic [CW-1:0] end_pos, sz;
  logic [7:0]    next_cur [NumCh];
  logic          extra    [NumCh];
  logic signed [9:0] v, dd, tt;

  always_comb begin
    last    = ({1'b0, index_q} + 9'd1) >= {1'b0, total_q};
    end_pos = horiz_q ? left_q + width_q : top_q + height_q;
    sz      = last ? end_pos - pos_q : size_q;

    out_data_d = '0;
    if (!active_q) begin
      out_data_d.no_band = 1'b1;
    end else begin
      out_data_d.band_x     = 16'(horiz_q ? pos_q : left_q);
      out_data_d.band_y     = 16'(horiz_q ? top_q : pos_q);
      out_data_d.band_w     = 16'(horiz_q ? sz : width_q);
      out_data_d.band_h     = 16'(horiz_q ? height_q : sz);
      out_data_d.band_color = {cur_q[0], cur_q[1], cur_q[2]};
      out_data_d.last_band  = last;
    end

    v  = '0;
    dd = '0;
    tt = '0;
    for (int i = 0; i < NumCh; i++) begin
      extra[i] = (index_q != '0) && (iv_q[i] != '0) && (cnt_q[i] == '0);
      v  = $signed({2'b00, cur_q[i]});
      dd = $signed({2'b00, delta_q[i]});
      tt = $signed({2'b00, t_ch[i]});
      if (rise_q[i]) begin
        v = v + dd;
        if (extra[i]) v = v + dd;
        if (v > tt) v = tt;
      end else begin
        v = v - dd;
        if (extra[i]) v = v - dd;
        if (v < tt) v = tt;
      end
      next_cur[i] = v[7:0];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_q   <= '0;
      to_q     <= '0;
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      horiz_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FROM_COLOR:  from_q   <= cfg_data_i;
        CFG_TO_COLOR:    to_q     <= cfg_data_i;
        CFG_AREA_LEFT:   left_q   <= cfg_data_i[CW-1:0];
        CFG_AREA_TOP:    top_q    <= cfg_data_i[CW-1:0];
        CFG_AREA_WIDTH:  width_q  <= cfg_data_i[CW-1:0];
        CFG_AREA_HEIGHT: height_q <= cfg_data_i[CW-1:0];
        CFG_HORIZONTAL:  horiz_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control state of the gradient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      index_q     <= '0;
      total_q     <= 8'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) out_valid_q <= 1'b0;
      if (cmd_i.finish) begin
        active_q <= 1'b1;
        index_q  <= '0;
        total_q  <= step_q;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (active_q) begin
          if (last) active_q <= 1'b0;
          else      index_q  <= index_q + 8'd1;
        end
      end
    end
  end

  // Setup and per-band payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      size_q <= '0;
      for (int i = 0; i < NumCh; i++) begin
        cur_q[i]   <= '0;
        delta_q[i] <= '0;
        iv_q[i]    <= '0;
        cnt_q[i]   <= '0;
        rise_q[i]  <= 1'b0;
      end
    end else begin
      if (cmd_i.prep) begin
        for (int i = 0; i < NumCh; i++) begin
          cur_q[i]   <= a_ch[i];
          rise_q[i]  <= rise[i];
          delta_q[i] <= '0;
          iv_q[i]    <= '0;
        end
      end
      if (cmd_i.div_store) begin
        unique case (cmd_i.op)
          OP_SIZE: size_q <= quo;
          OP_D:    delta_q[cmd_i.ch] <= (quo == '0) ? 8'd1 : quo[7:0];
          OP_IV:   iv_q[cmd_i.ch] <= quo[7:0];
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        pos_q <= horiz_q ? left_q : top_q;
        for (int i = 0; i < NumCh; i++) cnt_q[i] <= '0;
      end
      if (cmd_i.emit && active_q && !last) begin
        pos_q <= pos_q + size_q;
        for (int i = 0; i < NumCh; i++) begin
          cur_q[i] <= next_cur[i];
          cnt_q[i] <= ({1'b0, cnt_q[i]} + 9'd1 == {1'b0, iv_q[i]}) ? 8'd0
                                                                   : cnt_q[i] + 8'd1;
        end
      end
    end
  end

  // Setup scratch registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      span_q <= span;
      step_q <= step0;
      for (int i = 0; i < NumCh; i++) diff_q[i] <= dif[i];
    end
    if (cmd_i.step_one) step_q <= 8'd1;
    if (cmd_i.div_store) begin
      unique case (cmd_i.op)
        OP_Q:    q_q <= quo;
        OP_STEP: step_q <= (quo == '0) ? 8'd1 : quo[7:0];
        OP_K:    k_q <= quo[7:0];
        default: ;
      endcase
    end
    if (cmd_i.emit) out_data_q <= out_data_d;
  end

  assign sts_o.div_done     = div_done;
  assign sts_o.div_rem_nz   = (rem != '0);
  assign sts_o.div_quo_zero = (quo == '0);
  assign sts_o.step0_zero   = (step_q == '0);
  assign sts_o.step_gt1     = (step_q > 8'd1);
  assign sts_o.diff_gt_step = (diff_q[cmd_i.ch] > step_q);
  assign sts_o.out_free     = !out_valid_q;

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;
endmodule

FILE: rtl/core/bgf_ctrl.sv
// Controller: accepts requests and sequences the gradient setup divisions.
module bgf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  bgf_stream_if.sink    in_if,
  input  bgf_pkg::sts_t sts_i,
  output bgf_pkg::cmd_t cmd_o
);
  import bgf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DQ    = 4'd2;
  localparam logic [3:0] S_DSTEP = 4'd3;
  localparam logic [3:0] S_DSIZE = 4'd4;
  localparam logic [3:0] S_CD    = 4'd5;
  localparam logic [3:0] S_CK    = 4'd6;
  localparam logic [3:0] S_CIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       issued_q, issued_d;
  logic [1:0] ch_q, ch_d;
  logic [3:0] after_ch;

  always_comb begin
    cmd_o       = '0;
    cmd_o.ch    = ch_q;
    state_d     = state_q;
    issued_d    = issued_q;
    ch_d        = ch_q;
    in_if.ready = (state_q == S_IDLE);
    after_ch    = (ch_q == LastCh) ? S_FIN : S_CD;

    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) state_d = in_if.data.restart ? S_PREP : S_EMIT;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DQ;
      end
      S_DQ: begin
        cmd_o.op = OP_Q;
        if (!issued_q && sts_i.step0_zero) begin
          cmd_o.step_one = 1'b1;
          state_d        = S_DSIZE;
        end else if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          issued_d        = 1'b0;
          state_d         = sts_i.div_rem_nz ? S_DSTEP : S_DSIZE;
        end
      end
      S_DSTEP: begin
        cmd_o.op = OP_STEP;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          issued_d        = 1'b0;
          state_d         = S_DSIZE;
        end
      end
      S_DSIZE: begin
        cmd_o.op = OP_SIZE;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          issued_d        = 1'b0;
          ch_d            = '0;
          state_d         = S_CD;
        end
      end
      // Per-channel delta; single band counts keep delta and interval zero
      S_CD: begin
        cmd_o.op = OP_D;
        if (!issued_q && !sts_i.step_gt1) begin
          state_d = after_ch;
          ch_d    = ch_q + 2'd1;
        end else if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          issued_d        = 1'b0;
          if (sts_i.diff_gt_step) begin
            state_d = S_CK;
          end else begin
            state_d = after_ch;
            ch_d    = ch_q + 2'd1;
          end
        end
      end
      S_CK: begin
        cmd_o.op = OP_K;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          issued_d        = 1'b0;
          if (sts_i.div_quo_zero) begin
            state_d = after_ch;
            ch_d    = ch_q + 2'd1;
          end else begin
            state_d = S_CIV;
          end
        end
      end
      S_CIV: begin
        cmd_o.op = OP_IV;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          issued_d        = 1'b0;
          state_d         = after_ch;
          ch_d            = ch_q + 2'd1;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_EMIT;
      end
      // Wait for a free output register
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
      ch_q     <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ch_q     <= ch_d;
    end
  end
endmodule

FILE: rtl/core/banded_gradient_fill_generator_top.sv
// Top level of the banded gradient fill generator.
// Each input transfer yields exactly one result transfer. A request for the next band
// is accepted in the idle state; the band is then written to the output register once
// that register is free, and it holds the band until taken while the next request is
// accepted. A restart first runs the setup through one shared restoring divider, each
// division launched and then captured: between one and twelve divisions before its
// first band appears. A finished gradient answers a plain request with a no_band result.
module banded_gradient_fill_generator_top #(
  parameter int CoordBits = bgf_pkg::CoordBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  bgf_stream_if.sink   in_if,
  bgf_stream_if.source out_if
);
  import bgf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bgf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bgf_datapath #(.CoordBits(CoordBits)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_if     (out_if)
  );
endmodule

FILE: dv/banded_gradient_fill_generator_top_test.sv
// Self-checking testbench for the banded gradient fill generator top level.
module banded_gradient_fill_generator_top_test;
  import bgf_pkg::*;

  // Band geometry and color predictor with its own copy of the registers and state
  class band_scoreboard;
    logic [23:0] from_c, to_c;
    logic [15:0] left, top, wid, hgt;
    logic        horiz;
    bit          active;
    int unsigned idx, total, pos, size;
    int unsigned rgb[3], delta[3], ivl[3];
    bit          rising[3];
    out_item_t   pending[$];
    int          errors;

    function void reset_state();
      from_c = 0; to_c = 0; left = 0; top = 0; wid = 0; hgt = 0; horiz = 0;
      active = 0; idx = 0; total = 1; pos = 0; size = 0;
      for (int i = 0; i < 3; i++) begin
        rgb[i] = 0; delta[i] = 0; ivl[i] = 0; rising[i] = 0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] ridx, logic [23:0] val);
      case (ridx)
        CFG_FROM_COLOR:  from_c = val;
        CFG_TO_COLOR:    to_c = val;
        CFG_AREA_LEFT:   left = val[15:0];
        CFG_AREA_TOP:    top = val[15:0];
        CFG_AREA_WIDTH:  wid = val[15:0];
        CFG_AREA_HEIGHT: hgt = val[15:0];
        CFG_HORIZONTAL:  horiz = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned chan(logic [23:0] c, int i);
      return (c >> (16 - 8 * i)) & 8'hFF;
    endfunction

    // Band count, band size, deltas and extra-step intervals
    function void setup_gradient();
      int unsigned a, b, diff[3], cnt, span, q, d, iv, k;
      span = horiz ? wid : hgt;
      cnt = 0;
      for (int i = 0; i < 3; i++) begin
        a = chan(from_c, i); b = chan(to_c, i);
        rising[i] = !(a > b);
        diff[i] = rising[i] ? b - a : a - b;
        if (diff[i] > cnt) cnt = diff[i];
        rgb[i] = a;
      end
      if (cnt > span) cnt = span;
      if (cnt == 0) cnt = 1;
      else begin
        q = span / cnt;
        if (span != q * cnt) begin
          cnt = span / (q + 1);
          if (cnt > span) cnt = span;
          if (cnt == 0) cnt = 1;
        end
      end
      for (int i = 0; i < 3; i++) begin
        d = 0; iv = 0;
        if (cnt > 1) begin
          d = diff[i] / cnt;
          if (d == 0) d = 1;
          if (diff[i] > cnt) begin
            k = (diff[i] - cnt) / d;
            iv = (k != 0) ? cnt / k : 0;
          end
        end
        delta[i] = d & 8'hFF; ivl[i] = iv & 8'hFF;
      end
      total = cnt;
      size = (span / cnt) & 16'hFFFF;
      pos = horiz ? left : top;
      idx = 0;
      active = 1;
    endfunction

    function void step_colors();
      int v, t;
      bit extra;
      for (int i = 0; i < 3; i++) begin
        v = rgb[i]; t = chan(to_c, i);
        extra = idx != 0 && ivl[i] != 0 && (idx % ivl[i]) == 0;
        if (rising[i]) begin
          v += delta[i]; if (extra) v += delta[i]; if (v > t) v = t;
        end else begin
          v -= delta[i]; if (extra) v -= delta[i]; if (v < t) v = t;
        end
        rgb[i] = v & 8'hFF;
      end
    endfunction

    // Note an accepted request and queue the band it yields
    function void note_request(in_item_t req);
      out_item_t e;
      bit last;
      int unsigned sz, fin;
      e = '0;
      if (req.restart) setup_gradient();
      if (!active) begin
        e.no_band = 1;
      end else begin
        last = (idx + 1) >= total;
        if (last) begin
          fin = horiz ? left + wid : top + hgt;
          sz = (fin - pos) & 16'hFFFF;
        end else sz = size;
        e.band_x = horiz ? pos[15:0] : left;
        e.band_y = horiz ? top : pos[15:0];
        e.band_w = horiz ? sz[15:0] : wid;
        e.band_h = horiz ? hgt : sz[15:0];
        e.band_color = {rgb[0][7:0], rgb[1][7:0], rgb[2][7:0]};
        e.last_band = last;
        if (last) active = 0;
        else begin
          pos = (pos + size) & 16'hFFFF;
          step_colors();
          idx = (idx + 1) & 8'hFF;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_band(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected band, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.band_x !== e.band_x || got.band_y !== e.band_y ||
          got.band_w !== e.band_w || got.band_h !== e.band_h ||
          got.band_color !== e.band_color || got.last_band !== e.last_band ||
          got.no_band !== e.no_band) begin
        $display("%0t: band mismatch, expected x=%h y=%h w=%h h=%h c=%h l=%b n=%b",
                 $time, e.band_x, e.band_y, e.band_w, e.band_h, e.band_color,
                 e.last_band, e.no_band);
        $display("%0t:                actual   x=%h y=%h w=%h h=%h c=%h l=%b n=%b",
                 $time, got.band_x, got.band_y, got.band_w, got.band_h,
                 got.band_color, got.last_band, got.no_band);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_off = 0;

  bgf_stream_if #(.T(in_item_t))  req_ch ();
  bgf_stream_if #(.T(out_item_t)) band_ch ();

  banded_gradient_fill_generator_top u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(req_ch.sink), .out_if(band_ch.source)
  );

  band_scoreboard sb = new();

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    band_ch.ready = 0;
  end

  // Output side: random stall, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && band_ch.valid && band_ch.ready) sb.check_band(band_ch.data);
  end
  always @(negedge clk_i) begin
    band_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_cfg(logic [2:0] ridx, logic [23:0] val);
    cfg_we_i = 1; cfg_idx_i = ridx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    sb.write_reg(ridx, val);
  endtask

  // Offer one request, wait for the transfer, then drop valid
  task automatic send_req(bit rs);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 0;
      @(negedge clk_i);
    end
    req_ch.valid = 1;
    req_ch.data = '{restart: rs};
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_request('{restart: rs});
    @(negedge clk_i);
    req_ch.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Small spans keep the gradients short; sometimes a full-width span
  task automatic random_setup();
    write_cfg(CFG_FROM_COLOR, 24'($urandom()));
    write_cfg(CFG_TO_COLOR, 24'($urandom()));
    write_cfg(CFG_AREA_LEFT, 24'($urandom()));
    write_cfg(CFG_AREA_TOP, 24'($urandom()));
    write_cfg(CFG_AREA_WIDTH,
              24'(($urandom_range(9) == 0) ? $urandom() : $urandom_range(40)));
    write_cfg(CFG_AREA_HEIGHT,
              24'(($urandom_range(9) == 0) ? $urandom() : $urandom_range(40)));
    write_cfg(CFG_HORIZONTAL, 24'($urandom_range(1)));
  endtask

  task automatic run_gradient();
    int n;
    send_req(1);
    n = $urandom_range(12);
    for (int i = 0; i < n; i++) send_req($urandom_range(19) == 0);
  endtask

  initial begin
    sb.reset_state();
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: no gradient yet, then extremes
    send_req(0);
    drain();
    write_cfg(CFG_FROM_COLOR, 24'h000000);
    write_cfg(CFG_TO_COLOR, 24'hFFFFFF);
    write_cfg(CFG_AREA_LEFT, 24'h00FFFF);
    write_cfg(CFG_AREA_TOP, 24'h00FFFF);
    write_cfg(CFG_AREA_WIDTH, 24'h00FFFF);
    write_cfg(CFG_AREA_HEIGHT, 24'd7);
    write_cfg(CFG_HORIZONTAL, 24'd1);
    send_req(1); repeat (3) send_req(0);
    drain();
    write_cfg(CFG_FROM_COLOR, 24'hFF80FF);
    write_cfg(CFG_TO_COLOR, 24'h0010FE);
    write_cfg(CFG_HORIZONTAL, 24'd0);
    send_req(1); repeat (8) send_req(0);
    drain();
    // Zero span, then zero color difference
    write_cfg(CFG_AREA_HEIGHT, 24'd0);
    send_req(1); send_req(0);
    drain();
    write_cfg(CFG_AREA_HEIGHT, 24'd300);
    write_cfg(CFG_TO_COLOR, 24'hFF80FF);
    send_req(1); send_req(0); send_req(0);
    drain();

    // Long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end
      begin
        write_cfg(CFG_AREA_HEIGHT, 24'd5);
        write_cfg(CFG_TO_COLOR, 24'h102030);
        send_req(1); repeat (6) send_req(0);
      end
    join
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 27 : 0;
      recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 27 : 0;
      for (int g = 0; g < 25; g++) begin
        random_setup();
        run_gradient();
        drain();
      end
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
